/* src/ggx_pkg.sv */
// ----------------------------------------------------------------------------
// ggx_pkg
// Shared types and constants of the Green-Gauss node x-gradient unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ggx_pkg;

    localparam int NUM_COMPONENTS = 4;
    localparam int COMP_W         = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_AW       = 1;

    localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ACC_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [COMP_W-1:0] component;
        logic [63:0]       term_a;
        logic [63:0]       term_b;
        logic [63:0]       term_c;
        logic              add_term;
        logic              last_of_node;
        logic [31:0]       node_area;
    } ggx_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } ggx_state_t;

endpackage

`default_nettype wire

/* src/green_gauss_node_gradient_x_unit.sv */
// ----------------------------------------------------------------------------
// green_gauss_node_gradient_x_unit
// Green-Gauss x-gradient of four solution components at one mesh node.
// ----------------------------------------------------------------------------
// Each item is one triangle of the node. The front part forms the triangle's
// three vertex products in a two-stage pipeline and passes them through a
// two-entry queue to the back part, which handles one item at a time: it
// takes the item, makes three saturating adds for an interior triangle,
// and on the last triangle of a node runs the bit-serial division by six
// times the area, then saturates the signed quotient to 32 bits and loads
// the result. A zero area skips the division. A result waits in the output
// register until taken, which holds the back part on the next result.
// Exterior triangles that do not end a node are dropped in the front part.
// Components beyond the supported count are dropped without a result.
`default_nettype none

module green_gauss_node_gradient_x_unit
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // component[1:0], q_first, q_second, q_third, y_first, y_second, y_third,
    // node_area, zero fill to 232 bits
    input  wire logic [231:0]  s_axis_tdata,
    // is_exterior
    input  wire logic          s_axis_tuser,
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // gradient, out_component, area_zero, saturated, zero fill to 40 bits
    output logic [39:0]        m_axis_tdata
);

    logic               f_valid, f_ready, b_valid, b_ready;
    ggx_pkg::ggx_job_t  f_job, b_job;

    ggx_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .component    (s_axis_tdata[1:0]),
        .q_first      (s_axis_tdata[33:2]),
        .q_second     (s_axis_tdata[65:34]),
        .q_third      (s_axis_tdata[97:66]),
        .y_first      (s_axis_tdata[129:98]),
        .y_second     (s_axis_tdata[161:130]),
        .y_third      (s_axis_tdata[193:162]),
        .is_exterior  (s_axis_tuser),
        .last_of_node (s_axis_tlast),
        .node_area    (s_axis_tdata[225:194]),
        .job_valid    (f_valid),
        .job_ready    (f_ready),
        .job          (f_job)
    );

    ggx_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_job   (f_job),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_job   (b_job)
    );

    ggx_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* src/ggx_front.sv */
// ----------------------------------------------------------------------------
// ggx_front
// Accepts triangles, drops unused components and forms the three vertex
// products over two pipeline stages: normal sums, then the products.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        component,
    input  wire logic [31:0]       q_first,
    input  wire logic [31:0]       q_second,
    input  wire logic [31:0]       q_third,
    input  wire logic [31:0]       y_first,
    input  wire logic [31:0]       y_second,
    input  wire logic [31:0]       y_third,
    input  wire logic              is_exterior,
    input  wire logic              last_of_node,
    input  wire logic [31:0]       node_area,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output ggx_pkg::ggx_job_t      job
);

    logic                     s1_valid_reg;
    logic [1:0]               s1_comp_reg;
    logic signed [31:0]       s1_qa_reg, s1_qb_reg, s1_qc_reg;
    logic signed [32:0]       s1_sa_reg, s1_sb_reg, s1_sc_reg;
    logic                     s1_add_reg, s1_last_reg;
    logic [31:0]              s1_area_reg;
    logic                     s2_valid_reg;
    ggx_pkg::ggx_job_t        s2_job_reg;
    logic signed [63:0]       prod_a, prod_b, prod_c;
    logic                     s2_free, s1_free, keep;

    assign s2_free  = !s2_valid_reg || job_ready;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;
    assign keep     = {30'd0, component} < ggx_pkg::NUM_COMPONENTS;

    // Each normal sum reduces to one y difference.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_comp_reg <= component;
            s1_qa_reg   <= q_first;
            s1_qb_reg   <= q_second;
            s1_qc_reg   <= q_third;
            s1_sa_reg   <= {y_second[31], y_second} - {y_third[31], y_third};
            s1_sb_reg   <= {y_third[31], y_third} - {y_first[31], y_first};
            s1_sc_reg   <= {y_first[31], y_first} - {y_second[31], y_second};
            s1_add_reg  <= !is_exterior;
            s1_last_reg <= last_of_node;
            s1_area_reg <= node_area;
        end
    end

    // Each product of a 32-bit value and a 33-bit difference fits 64 bits.
    assign prod_a = 64'(s1_qa_reg) * 64'(s1_sa_reg);
    assign prod_b = 64'(s1_qb_reg) * 64'(s1_sb_reg);
    assign prod_c = 64'(s1_qc_reg) * 64'(s1_sc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg && (s1_add_reg || s1_last_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_job_reg.component    <= s1_comp_reg;
            s2_job_reg.term_a       <= prod_a;
            s2_job_reg.term_b       <= prod_b;
            s2_job_reg.term_c       <= prod_c;
            s2_job_reg.add_term     <= s1_add_reg;
            s2_job_reg.last_of_node <= s1_last_reg;
            s2_job_reg.node_area    <= s1_area_reg;
        end
    end

    assign job_valid = s2_valid_reg;
    assign job       = s2_job_reg;

endmodule

`default_nettype wire

/* src/ggx_queue.sv */
// ----------------------------------------------------------------------------
// ggx_queue
// Short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  ggx_pkg::ggx_job_t      wr_job,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output ggx_pkg::ggx_job_t      rd_job
);

    ggx_pkg::ggx_job_t             slot_reg [ggx_pkg::QUEUE_DEPTH];
    logic [ggx_pkg::QUEUE_AW-1:0]  wp_reg, rp_reg;
    logic [ggx_pkg::QUEUE_AW:0]    cnt_reg;
    logic                          wr_en, rd_en;

    assign wr_ready = cnt_reg != (ggx_pkg::QUEUE_AW+1)'(ggx_pkg::QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_job   = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wp_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

/* src/ggx_back.sv */
// ----------------------------------------------------------------------------
// ggx_back
// Saturating accumulation per component and, at node end, a bit-serial
// division of the accumulator magnitude by six times a nonzero area.
// ----------------------------------------------------------------------------
`default_nettype none

module ggx_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  ggx_pkg::ggx_job_t      job,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [39:0]            res_data
);

    ggx_pkg::ggx_state_t  state_reg, state_next;
    logic [63:0]          acc_reg [ggx_pkg::NUM_COMPONENTS];
    logic                 ovf_reg [ggx_pkg::NUM_COMPONENTS];
    ggx_pkg::ggx_job_t    job_reg;
    logic [63:0]          quo_reg;
    logic [35:0]          rem_reg;
    logic [34:0]          den_reg;
    logic [6:0]           cnt_reg;
    logic [1:0]           step_reg;
    logic                 neg_reg, sat_reg, zero_reg;
    logic [31:0]          grad_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_comp_reg;
    logic                 out_zero_reg, out_sat_reg;
    logic [63:0]          acc_cur, sum, term_cur;
    logic                 add_ovf;
    logic [35:0]          rem_sh;
    logic                 fits;

    // The three vertex products are added one per cycle, each saturating.
    assign term_cur = (step_reg == 2'd0) ? job_reg.term_a
                    : (step_reg == 2'd1) ? job_reg.term_b : job_reg.term_c;
    assign acc_cur = acc_reg[job_reg.component];
    assign sum     = acc_cur + term_cur;
    assign add_ovf = (acc_cur[63] == term_cur[63]) && (sum[63] != acc_cur[63]);
    assign rem_sh  = {rem_reg[34:0], quo_reg[63]};
    assign fits    = rem_sh >= {1'b0, den_reg};

    assign job_ready = state_reg == ggx_pkg::ST_IDLE;
    assign res_valid = out_valid_reg;
    assign res_data  = {4'd0, out_sat_reg, out_zero_reg, out_comp_reg, grad_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ggx_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ggx_pkg::ST_ACC;
                end
            end
            ggx_pkg::ST_ACC:
            begin
                if (job_reg.add_term && step_reg != 2'd2)
                begin
                    state_next = ggx_pkg::ST_ACC;
                end
                else if (!job_reg.last_of_node)
                begin
                    state_next = ggx_pkg::ST_IDLE;
                end
                else if (job_reg.node_area == '0)
                begin
                    state_next = ggx_pkg::ST_FIX;
                end
                else
                begin
                    state_next = ggx_pkg::ST_DIV;
                end
            end
            ggx_pkg::ST_DIV:
            begin
                if (cnt_reg == 7'd63)
                begin
                    state_next = ggx_pkg::ST_FIX;
                end
            end
            ggx_pkg::ST_FIX:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    state_next = ggx_pkg::ST_OUT;
                end
            end
            ggx_pkg::ST_OUT:
            begin
                state_next = ggx_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ggx_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ggx_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ggx_pkg::NUM_COMPONENTS; i++)
            begin
                acc_reg[i] <= '0;
                ovf_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ggx_pkg::ST_ACC:
                begin
                    if (job_reg.add_term)
                    begin
                        acc_reg[job_reg.component] <= add_ovf
                            ? (acc_cur[63] ? ggx_pkg::ACC_MIN : ggx_pkg::ACC_MAX) : sum;
                        if (add_ovf)
                        begin
                            ovf_reg[job_reg.component] <= 1'b1;
                        end
                    end
                end
                ggx_pkg::ST_OUT:
                begin
                    out_valid_reg                <= 1'b1;
                    acc_reg[job_reg.component]   <= '0;
                    ovf_reg[job_reg.component]   <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ggx_pkg::ST_IDLE:
            begin
                job_reg  <= job;
                step_reg <= '0;
            end
            ggx_pkg::ST_ACC:
            begin
                logic [63:0] a;
                a = job_reg.add_term
                    ? (add_ovf ? (acc_cur[63] ? ggx_pkg::ACC_MIN : ggx_pkg::ACC_MAX) : sum)
                    : acc_cur;
                step_reg <= step_reg + 2'd1;
                neg_reg  <= a[63];
                quo_reg  <= a[63] ? (64'd0 - a) : a;
                zero_reg <= job_reg.node_area == '0;
                sat_reg  <= ovf_reg[job_reg.component] || (job_reg.add_term && add_ovf);
                rem_reg  <= '0;
                cnt_reg  <= '0;
                den_reg  <= {1'b0, job_reg.node_area, 2'b00}
                          + {2'b00, job_reg.node_area, 1'b0};
            end
            ggx_pkg::ST_DIV:
            begin
                rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                quo_reg <= {quo_reg[62:0], fits};
                cnt_reg <= cnt_reg + 7'd1;
            end
            ggx_pkg::ST_FIX:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    if (zero_reg)
                    begin
                        if (quo_reg == '0)
                        begin
                            grad_reg <= '0;
                        end
                        else
                        begin
                            grad_reg <= neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                            sat_reg  <= 1'b1;
                        end
                    end
                    else if (neg_reg)
                    begin
                        if (quo_reg > 64'h8000_0000)
                        begin
                            grad_reg <= 32'h8000_0000;
                            sat_reg  <= 1'b1;
                        end
                        else
                        begin
                            grad_reg <= 32'd0 - quo_reg[31:0];
                        end
                    end
                    else if (quo_reg > 64'h7FFF_FFFF)
                    begin
                        grad_reg <= 32'h7FFF_FFFF;
                        sat_reg  <= 1'b1;
                    end
                    else
                    begin
                        grad_reg <= quo_reg[31:0];
                    end
                end
            end
            ggx_pkg::ST_OUT:
            begin
                out_comp_reg <= job_reg.component;
                out_zero_reg <= zero_reg;
                out_sat_reg  <= sat_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* dv/tb_green_gauss_node_gradient_x_unit.sv */
// ----------------------------------------------------------------------------
// tb_green_gauss_node_gradient_x_unit
// Self-checking testbench of the Green-Gauss node x-gradient unit.
// ----------------------------------------------------------------------------
// Triangles are sent on the input stream in bursts with random gaps. A local
// model accumulates the per-component term and predicts the gradient that
// is emitted on the last triangle of each node. Results are checked in order
// against a queue of predicted gradients, while the output side stalls on its
// own pattern and at one point holds off long enough to fill the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_green_gauss_node_gradient_x_unit;

    typedef struct packed {
        logic       saturated;
        logic       area_zero;
        logic [1:0] comp;
        logic [31:0] gradient;
    } grad_res_t;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [231:0]  s_axis_tdata;
    logic          s_axis_tuser;
    logic          s_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [39:0]   m_axis_tdata;

    logic signed [63:0] node_sum [ggx_pkg::NUM_COMPONENTS];
    logic               sum_clamped [ggx_pkg::NUM_COMPONENTS];
    grad_res_t          expected_grads [$];
    int                 mismatches;
    int                 hold_off;
    bit                 hold_req;
    bit                 hold_armed;

    green_gauss_node_gradient_x_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     inout logic ov);
        logic signed [63:0] s;
        begin
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
            begin
                ov = 1'b1;
                s = a[63] ? S64_MIN : S64_MAX;
            end
            return s;
        end
    endfunction

    task automatic predict_triangle(input logic [1:0] c, input logic signed [31:0] qa,
                                    input logic signed [31:0] qb,
                                    input logic signed [31:0] qc,
                                    input logic signed [31:0] ya,
                                    input logic signed [31:0] yb,
                                    input logic signed [31:0] yc,
                                    input logic ext, input logic last,
                                    input logic [31:0] area);
        logic signed [63:0] na, nb, nc, acc;
        logic [63:0] mag, quo;
        logic ov, sat;
        grad_res_t r;
        begin
            if (c >= ggx_pkg::NUM_COMPONENTS)
                return;
            if (!ext)
            begin
                na = 64'(yc) - 64'(yb);
                nb = 64'(ya) - 64'(yc);
                nc = 64'(yb) - 64'(ya);
                ov = 1'b0;
                acc = node_sum[c];
                acc = clamp_add(acc, 64'(qa) * (nb + nc), ov);
                acc = clamp_add(acc, 64'(qb) * (na + nc), ov);
                acc = clamp_add(acc, 64'(qc) * (nb + na), ov);
                node_sum[c] = acc;
                if (ov)
                    sum_clamped[c] = 1'b1;
            end
            if (!last)
                return;
            acc = node_sum[c];
            sat = sum_clamped[c];
            r.comp = c;
            r.area_zero = (area == 32'd0);
            if (area == 32'd0)
            begin
                if (acc > 0)
                begin
                    r.gradient = 32'h7FFF_FFFF;
                    sat = 1'b1;
                end
                else if (acc < 0)
                begin
                    r.gradient = 32'h8000_0000;
                    sat = 1'b1;
                end
                else
                    r.gradient = 32'd0;
            end
            else
            begin
                mag = acc[63] ? 64'd0 - 64'(acc) : 64'(acc);
                quo = mag / ({32'd0, area} * 64'd6);
                if (acc[63])
                begin
                    if (quo > 64'h8000_0000)
                    begin
                        r.gradient = 32'h8000_0000;
                        sat = 1'b1;
                    end
                    else
                        r.gradient = 32'(64'd0 - quo);
                end
                else if (quo > 64'h7FFF_FFFF)
                begin
                    r.gradient = 32'h7FFF_FFFF;
                    sat = 1'b1;
                end
                else
                    r.gradient = quo[31:0];
            end
            r.saturated = sat;
            expected_grads.insert(expected_grads.size(), r);
            node_sum[c] = 64'sd0;
            sum_clamped[c] = 1'b0;
        end
    endtask

    task automatic send_triangle(input logic [1:0] c, input logic [31:0] qa,
                                 input logic [31:0] qb, input logic [31:0] qc,
                                 input logic [31:0] ya, input logic [31:0] yb,
                                 input logic [31:0] yc, input logic ext,
                                 input logic last, input logic [31:0] area);
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {6'd0, area, yc, yb, ya, qc, qb, qa, c};
            s_axis_tuser  <= ext;
            s_axis_tlast  <= last;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            predict_triangle(c, qa, qb, qc, ya, yb, yc, ext, last, area);
        end
    endtask

    task automatic idle_gap();
        int n;
        begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (n > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 20) << 16;
            3: return -($urandom_range(0, 20) << 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_node(input int tris, input bit big);
        logic [1:0] c;
        logic [31:0] area;
        begin
            c = $urandom_range(0, 3);
            area = ($urandom_range(0, 9) == 0) ? 32'd0 :
                   (big ? $urandom : $urandom_range(1, 32'h0004_0000));
            for (int i = 0; i < tris; i++)
            begin
                if (big)
                    send_triangle(c, rand_word(), rand_word(), rand_word(),
                                  rand_word(), rand_word(), rand_word(),
                                  $urandom_range(0, 4) == 0, i == tris - 1, area);
                else
                    send_triangle(c, $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                                  $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                                  $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                                  $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                                  $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                                  $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                                  $urandom_range(0, 4) == 0, i == tris - 1, area);
                idle_gap();
            end
        end
    endtask

    task automatic test_directed();
        begin
            send_triangle(2'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          32'h0000_0000, 32'h0001_0000, 32'h0003_0000, 1'b0, 1'b1, 32'h0001_0000);
            send_triangle(2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'd0);
            send_triangle(2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 32'd1);
            for (int i = 0; i < 8; i++)
                send_triangle(2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, i == 7,
                              32'hFFFF_FFFF);
            send_triangle(2'd3, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h1, 32'h0, 32'hFFFF_FFFF,
                          1'b0, 1'b0, 32'h0);
            send_triangle(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          1'b1, 1'b1, 32'd0);
            send_triangle(2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 32'd0);
            send_triangle(2'd2, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
                          1'b0, 1'b1, 32'd0);
            send_triangle(2'd2, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0,
                          1'b0, 1'b1, 32'd0);
            send_triangle(2'd1, 32'h0000_0100, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0,
                          1'b0, 1'b1, 32'hFFFF_FFFF);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic test_random_nodes();
        int sent;
        begin
            sent = 0;
            while (sent < 1650)
            begin
                int n;
                n = $urandom_range(1, 8);
                random_node(n, $urandom_range(0, 2) == 0);
                sent += n;
            end
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic test_backpressure();
        begin
            hold_req = 1'b1;
            for (int i = 0; i < 30; i++)
                send_triangle($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_off <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_req && hold_armed)
        begin
            m_axis_tready <= 1'b0;
            hold_off <= 400;
            hold_armed <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 15) < 11);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            grad_res_t got, want;
            got = grad_res_t'(m_axis_tdata[35:0]);
            if (expected_grads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected gradient result %h", got);
            end
            else
            begin
                want = expected_grads.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Gradient mismatch: expected grad=%h comp=%0d zero=%b ",
                                  "sat=%b, got grad=%h comp=%0d zero=%b sat=%b"},
                                 want.gradient, want.comp, want.area_zero, want.saturated,
                                 got.gradient, got.comp, got.area_zero, got.saturated);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        hold_req = 1'b0;
        mismatches = 0;
        for (int i = 0; i < ggx_pkg::NUM_COMPONENTS; i++)
        begin
            node_sum[i] = 64'sd0;
            sum_clamped[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_nodes();
        while (expected_grads.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_grads.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/ggx_pkg.sv
src/ggx_front.sv
src/ggx_queue.sv
src/ggx_back.sv
src/green_gauss_node_gradient_x_unit.sv
dv/tb_green_gauss_node_gradient_x_unit.sv
